// ===== sv/bpme_pkg.sv =====
package bpme_pkg;

  // Default geometry of the fixed-point evaluation.
  localparam int FRAC_BITS_DEF  = 24;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths of the channels and registers.
  localparam int CMD_W      = 1;
  localparam int DT_W       = 16;
  localparam int SPEED_W    = 24;
  localparam int PT_W       = 16;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_RESTART = 1'b1;
  localparam logic             ORDER_CUBIC = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_POINT = 3'd0,
    REG_CONTROL_A   = 3'd1,
    REG_CONTROL_B   = 3'd2,
    REG_END_POINT   = 3'd3,
    REG_SPEED       = 3'd4,
    REG_CURVE_ORDER = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_t;

  // One entry per multiply that the sequencer issues to the serial unit.
  typedef enum logic [3:0] {
    OP_POS,
    OP_UU,
    OP_TT,
    OP_W0,
    OP_W1,
    OP_W2,
    OP_W3,
    OP_X0,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_Y0,
    OP_Y1,
    OP_Y2,
    OP_Y3
  } op_t;

endpackage

// ===== sv/bpme_in_if.sv =====
interface bpme_in_if import bpme_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [DT_W-1:0]  time_delay;

  modport source (output valid, cmd, time_delay, input ready);
  modport sink   (input valid, cmd, time_delay, output ready);
  modport mon    (input valid, cmd, time_delay, ready);
endinterface

// ===== sv/bpme_out_if.sv =====
interface bpme_out_if import bpme_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [FRAC_BITS:0]           position;
  logic                         finished;

  modport source (output valid, point_x, point_y, position, finished, input ready);
  modport sink   (input valid, point_x, point_y, position, finished, output ready);
  modport mon    (input valid, point_x, point_y, position, finished, ready);
endinterface

// ===== sv/bpme_cfg_if.sv =====
interface bpme_cfg_if import bpme_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bpme_serial_mult.sv =====
module bpme_serial_mult import bpme_pkg::*; #(
  parameter int AW = SPEED_W,
  parameter int BW = DT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic [BW-1:0]           b,
  output logic                    done,
  output logic signed [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic signed [AW:0]   hi_r;
  logic [BW-1:0]        lo_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [AW:0]   addend;
  logic signed [AW:0]   sum;

  // One multiplier bit per cycle: add the multiplicand if the bit is set,
  // then shift the partial product right by one.
  always_comb begin
    addend = lo_r[0] ? {a_r[AW-1], a_r} : '0;
    sum    = hi_r + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        hi_r   <= '0;
        lo_r   <= b;
        cnt_r  <= CW'(BW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= {sum[AW], sum[AW:1]};
        lo_r  <= {sum[0], lo_r[BW-1:1]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = {hi_r[AW-1:0], lo_r};

endmodule

// ===== sv/bezier_path_motion_evaluator_unit.sv =====
// Channel  Direction  Payload                                   Accepted when
// in_ch    input      cmd, time_delay                           valid & ready
// out_ch   output     point_x, point_y, position, finished      valid & ready
// cfg_ch   input      index, data (six registers)               valid & ready
//
// Every product goes through one shared bit-serial multiplier, one multiplier
// bit per cycle. A running cubic tick needs 15 multiplies, a cubic restart 14;
// in quadratic mode a tick needs 12 and a restart 11. Items are accepted in
// ST_IDLE and results loaded in ST_OUT; a tick while finished skips the
// multiplies. Synchronous reset clears control state but marks the motion
// finished, and resets the configuration registers. The output register lets
// a new item be accepted while the last result still waits; the sequencer
// stalls before loading it until it is free.
module bezier_path_motion_evaluator_unit import bpme_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bpme_in_if.sink       in_ch,
  bpme_out_if.source    out_ch,
  bpme_cfg_if.sink      cfg_ch
);

  // Widths of the fixed-point datapath.
  localparam int POS_W  = FRAC_BITS + 1;
  localparam int W_W    = FRAC_BITS + 2;
  localparam int MA_W   = (FRAC_BITS + 2 > SPEED_W) ? FRAC_BITS + 2 : SPEED_W;
  localparam int MB_W   = (FRAC_BITS + 2 > DT_W) ? FRAC_BITS + 2 : DT_W;
  localparam int PROD_W = MA_W + MB_W;
  localparam int PSUM_W = PROD_W + 1;
  // The weights sum to at most eight times 1.0, so the weighted sum of four
  // coordinates needs PT_W + 4 integer bits including the sign.
  localparam int QW     = (PT_W + 4 > COORD_BITS + 1) ? PT_W + 4 : COORD_BITS + 1;
  localparam int SUM_W  = FRAC_BITS + QW;

  localparam logic [POS_W-1:0]         ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PSUM_W-1:0] ONE_S  = PSUM_W'(ONE_T);
  localparam logic [PROD_W-1:0]        HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]  HALF_S = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0]     C_MAX  =
    {{(QW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [QW-1:0]     C_MIN  =
    {{(QW - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  // Configuration registers.
  logic [CFG_DATA_W-1:0] start_pt_r;
  logic [CFG_DATA_W-1:0] ctl_a_r;
  logic [CFG_DATA_W-1:0] ctl_b_r;
  logic [CFG_DATA_W-1:0] end_pt_r;
  logic [SPEED_W-1:0]    speed_r;
  logic                  order_r;

  // Control state.
  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  done_r, done_nxt;
  logic signed [COORD_BITS-1:0] held_x_r, held_x_nxt;
  logic signed [COORD_BITS-1:0] held_y_r, held_y_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers of the evaluation.
  logic [DT_W-1:0]       dt_r, dt_nxt;
  logic [POS_W-1:0]      uu_r, uu_nxt;
  logic [POS_W-1:0]      tt_r, tt_nxt;
  logic [W_W-1:0]        w0_r, w0_nxt;
  logic [W_W-1:0]        w1_r, w1_nxt;
  logic [W_W-1:0]        w2_r, w2_nxt;
  logic [W_W-1:0]        w3_r, w3_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;

  // Output register.
  logic signed [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic signed [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic                  out_fin_r, out_fin_nxt;

  // Multiplier hookup.
  logic                    mul_start;
  logic signed [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]         mul_b;
  logic                    mul_done;
  logic signed [PROD_W-1:0] mul_prod;

  // Derived datapath values.
  logic [POS_W-1:0]        u_val;
  logic [PROD_W-1:0]       rnd_sum;
  logic [POS_W-1:0]        rnd_v;
  logic [W_W-1:0]          rnd_w;
  logic signed [PSUM_W-1:0] psum;
  logic signed [SUM_W-1:0] acc_add;
  logic signed [SUM_W-1:0] rs;
  logic signed [QW-1:0]    rq;
  logic signed [COORD_BITS-1:0] coord_sat;

  bpme_serial_mult #(
    .AW (MA_W),
    .BW (MB_W)
  ) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Register writes are always taken; an index past the list is dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pt_r <= '0;
      ctl_a_r    <= '0;
      ctl_b_r    <= '0;
      end_pt_r   <= '0;
      speed_r    <= '0;
      order_r    <= ORDER_CUBIC;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_START_POINT: start_pt_r <= cfg_ch.data;
        REG_CONTROL_A:   ctl_a_r    <= cfg_ch.data;
        REG_CONTROL_B:   ctl_b_r    <= cfg_ch.data;
        REG_END_POINT:   end_pt_r   <= cfg_ch.data;
        REG_SPEED:       speed_r    <= cfg_ch.data[SPEED_W-1:0];
        REG_CURVE_ORDER: order_r    <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // The curve parameter t is pos_r itself; u = 1.0 - t.
  assign u_val = ONE_T - pos_r;

  // Operands of the multiply that the sequencer is about to issue. Points
  // hold x in the low half and y in the high half.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_POS: begin
        mul_a = MA_W'($signed(speed_r));
        mul_b = MB_W'(dt_r);
      end
      OP_UU: begin
        mul_a = MA_W'(u_val);
        mul_b = MB_W'(u_val);
      end
      OP_TT: begin
        mul_a = MA_W'(pos_r);
        mul_b = MB_W'(pos_r);
      end
      OP_W0: begin
        mul_a = MA_W'(uu_r);
        mul_b = MB_W'(u_val);
      end
      OP_W1: begin
        // The quadratic middle weight is built from u * t instead.
        mul_a = (order_r == ORDER_CUBIC) ? MA_W'(uu_r) : MA_W'(u_val);
        mul_b = MB_W'(pos_r);
      end
      OP_W2: begin
        mul_a = MA_W'(tt_r);
        mul_b = MB_W'(u_val);
      end
      OP_W3: begin
        mul_a = MA_W'(tt_r);
        mul_b = MB_W'(pos_r);
      end
      OP_X0: begin
        mul_a = MA_W'($signed(start_pt_r[PT_W-1:0]));
        mul_b = MB_W'(w0_r);
      end
      OP_X1: begin
        mul_a = MA_W'($signed(ctl_a_r[PT_W-1:0]));
        mul_b = MB_W'(w1_r);
      end
      OP_X2: begin
        mul_a = MA_W'($signed(ctl_b_r[PT_W-1:0]));
        mul_b = MB_W'(w2_r);
      end
      OP_X3: begin
        mul_a = MA_W'($signed(end_pt_r[PT_W-1:0]));
        mul_b = MB_W'(w3_r);
      end
      OP_Y0: begin
        mul_a = MA_W'($signed(start_pt_r[2*PT_W-1:PT_W]));
        mul_b = MB_W'(w0_r);
      end
      OP_Y1: begin
        mul_a = MA_W'($signed(ctl_a_r[2*PT_W-1:PT_W]));
        mul_b = MB_W'(w1_r);
      end
      OP_Y2: begin
        mul_a = MA_W'($signed(ctl_b_r[2*PT_W-1:PT_W]));
        mul_b = MB_W'(w2_r);
      end
      OP_Y3: begin
        mul_a = MA_W'($signed(end_pt_r[2*PT_W-1:PT_W]));
        mul_b = MB_W'(w3_r);
      end
      default: begin
      end
    endcase
  end

  // Round a nonnegative product back to FRAC_BITS fraction bits, halves up.
  assign rnd_sum = mul_prod + HALF_P;
  assign rnd_v   = rnd_sum[FRAC_BITS +: POS_W];
  assign rnd_w   = W_W'(rnd_v);

  // Position update: t + speed * time_delay, before clamping.
  assign psum = PSUM_W'($signed({1'b0, pos_r})) + PSUM_W'(mul_prod);

  // Weighted sum, then floor((sum + 1/2) / 1.0) and saturation to the
  // coordinate range.
  assign acc_add = acc_r + SUM_W'(mul_prod);
  assign rs      = acc_add + HALF_S;
  assign rq      = rs[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (rq > C_MAX) begin
      coord_sat = C_MAX[COORD_BITS-1:0];
    end else if (rq < C_MIN) begin
      coord_sat = C_MIN[COORD_BITS-1:0];
    end else begin
      coord_sat = rq[COORD_BITS-1:0];
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Sequencer: each state of ST_ISSUE / ST_WAIT runs one multiply, and its
  // completion stores the result and picks the next multiply or, after the last, ST_OUT.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    dt_nxt        = dt_r;
    uu_nxt        = uu_r;
    tt_nxt        = tt_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    w3_nxt        = w3_r;
    acc_nxt       = acc_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_pos_nxt   = out_pos_r;
    out_fin_nxt   = out_fin_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          dt_nxt = in_ch.time_delay;
          if (in_ch.cmd == CMD_RESTART) begin
            pos_nxt   = '0;
            done_nxt  = 1'b0;
            op_nxt    = OP_UU;
            state_nxt = ST_ISSUE;
          end else if (done_r) begin
            // A tick after the end repeats the held result.
            state_nxt = ST_OUT;
          end else begin
            op_nxt    = OP_POS;
            state_nxt = ST_ISSUE;
          end
        end
      end

      ST_ISSUE: begin
        mul_start = 1'b1;
        if (op_r == OP_X0 || op_r == OP_Y0) begin
          acc_nxt = '0;
        end
        state_nxt = ST_WAIT;
      end

      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_ISSUE;
          unique case (op_r)
            OP_POS: begin
              // Clamp below at 0; going past 1.0 ends the motion, while
              // landing exactly on 1.0 does not.
              if (psum[PSUM_W-1]) begin
                pos_nxt = '0;
              end else if (psum > ONE_S) begin
                pos_nxt  = ONE_T;
                done_nxt = 1'b1;
              end else begin
                pos_nxt = psum[POS_W-1:0];
              end
              op_nxt = OP_UU;
            end
            OP_UU: begin
              uu_nxt = rnd_v;
              op_nxt = OP_TT;
            end
            OP_TT: begin
              tt_nxt = rnd_v;
              op_nxt = (order_r == ORDER_CUBIC) ? OP_W0 : OP_W1;
            end
            OP_W0: begin
              w0_nxt = rnd_w;
              op_nxt = OP_W1;
            end
            OP_W1: begin
              if (order_r == ORDER_CUBIC) begin
                w1_nxt = rnd_w + (rnd_w << 1);
                op_nxt = OP_W2;
              end else begin
                w0_nxt = W_W'(uu_r);
                w1_nxt = rnd_w << 1;
                w2_nxt = '0;
                w3_nxt = W_W'(tt_r);
                op_nxt = OP_X0;
              end
            end
            OP_W2: begin
              w2_nxt = rnd_w + (rnd_w << 1);
              op_nxt = OP_W3;
            end
            OP_W3: begin
              w3_nxt = rnd_w;
              op_nxt = OP_X0;
            end
            OP_X0: begin
              acc_nxt = acc_add;
              op_nxt  = OP_X1;
            end
            OP_X1: begin
              acc_nxt = acc_add;
              op_nxt  = OP_X2;
            end
            OP_X2: begin
              acc_nxt = acc_add;
              op_nxt  = OP_X3;
            end
            OP_X3: begin
              held_x_nxt = coord_sat;
              op_nxt     = OP_Y0;
            end
            OP_Y0: begin
              acc_nxt = acc_add;
              op_nxt  = OP_Y1;
            end
            OP_Y1: begin
              acc_nxt = acc_add;
              op_nxt  = OP_Y2;
            end
            OP_Y2: begin
              acc_nxt = acc_add;
              op_nxt  = OP_Y3;
            end
            OP_Y3: begin
              held_y_nxt = coord_sat;
              state_nxt  = ST_OUT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_x_nxt     = held_x_r;
          out_y_nxt     = held_y_r;
          out_pos_nxt   = pos_r;
          out_fin_nxt   = done_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_POS;
      pos_r       <= '0;
      done_r      <= 1'b1;
      held_x_r    <= '0;
      held_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r      <= dt_nxt;
    uu_r      <= uu_nxt;
    tt_r      <= tt_nxt;
    w0_r      <= w0_nxt;
    w1_r      <= w1_nxt;
    w2_r      <= w2_nxt;
    w3_r      <= w3_nxt;
    acc_r     <= acc_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_pos_r <= out_pos_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.point_x  = out_x_r;
  assign out_ch.point_y  = out_y_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.finished = out_fin_r;

endmodule

// ===== sv/bpme_checker.sv =====
module bpme_checker import bpme_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_point_x,
  input logic [COORD_BITS-1:0] out_point_y,
  input logic [FRAC_BITS:0]    out_position,
  input logic                  out_finished
);

  localparam logic [FRAC_BITS:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_point_x) && $stable(out_point_y) &&
      $stable(out_position) && $stable(out_finished))
    else $error("result changed while stalled");

  // Items are worked on one at a time, so an accepted item closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after an accepted item");

  // The clamp keeps the curve parameter within [0, 1.0].
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= ONE_T)
    else $error("position beyond 1.0");

endmodule

bind bezier_path_motion_evaluator_unit bpme_checker #(
  .FRAC_BITS  (FRAC_BITS),
  .COORD_BITS (COORD_BITS)
) u_bpme_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_point_x  (out_ch.point_x),
  .out_point_y  (out_ch.point_y),
  .out_position (out_ch.position),
  .out_finished (out_ch.finished)
);

// ===== sim/bpme_tb_pkg.sv =====
`timescale 1ns / 100ps

package bpme_tb_pkg;
  import bpme_pkg::*;

  localparam longint UNIT_T  = longint'(1) << FRAC_BITS_DEF;
  localparam longint HALF_T  = longint'(1) << (FRAC_BITS_DEF - 1);
  localparam longint CRD_MAX = (longint'(1) << (COORD_BITS_DEF - 1)) - 1;
  localparam longint CRD_MIN = -(longint'(1) << (COORD_BITS_DEF - 1));

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] x;
    logic signed [COORD_BITS_DEF-1:0] y;
    logic [FRAC_BITS_DEF:0]           position;
    logic                             finished;
  } curve_sample_t;

  // Tracks the curve registers and the motion state, and holds the samples
  // that the block still owes, oldest first.
  class motion_scoreboard;
    logic [CFG_DATA_W-1:0]            start_pt, ctrl_a, ctrl_b, end_pt;
    logic signed [SPEED_W-1:0]        speed;
    logic                             order;
    longint                           t_acc;
    bit                               done;
    logic signed [COORD_BITS_DEF-1:0] held_x, held_y;
    curve_sample_t                    pending_samples[$];
    int failures, checked, restarts, ticks, quad_items, finishes, landings, zero_clamps;

    function new();
      start_pt = '0;
      ctrl_a = '0;
      ctrl_b = '0;
      end_pt = '0;
      speed = '0;
      order = ORDER_CUBIC;
      t_acc = 0;
      done = 1'b1;
      held_x = '0;
      held_y = '0;
      failures = 0;
      checked = 0;
      restarts = 0;
      ticks = 0;
      quad_items = 0;
      finishes = 0;
      landings = 0;
      zero_clamps = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_POINT: start_pt = data;
        REG_CONTROL_A:   ctrl_a = data;
        REG_CONTROL_B:   ctrl_b = data;
        REG_END_POINT:   end_pt = data;
        REG_SPEED:       speed = data[SPEED_W-1:0];
        REG_CURVE_ORDER: order = data[0];
        default: ;
      endcase
    endfunction

    function longint axis_of(logic [CFG_DATA_W-1:0] pt, bit is_y);
      logic signed [PT_W-1:0] h;
      h = is_y ? pt[2*PT_W-1:PT_W] : pt[PT_W-1:0];
      return longint'(h);
    endfunction

    // Rounds half up back to the fraction width; floor for negative values.
    function longint round_frac(longint v);
      return (v + HALF_T) >>> FRAC_BITS_DEF;
    endfunction

    function longint clip(longint v);
      if (v > CRD_MAX) return CRD_MAX;
      if (v < CRD_MIN) return CRD_MIN;
      return v;
    endfunction

    function longint curve_axis(longint t, bit is_y);
      longint p0, p1, p2, p3, u, uu, tt, w0, w1, w2, w3;
      p0 = axis_of(start_pt, is_y);
      p1 = axis_of(ctrl_a, is_y);
      p2 = axis_of(ctrl_b, is_y);
      p3 = axis_of(end_pt, is_y);
      if (t <= 0) return clip(p0);
      if (t >= UNIT_T) return clip(p3);
      u = UNIT_T - t;
      uu = round_frac(u * u);
      tt = round_frac(t * t);
      if (order == ORDER_CUBIC) begin
        w0 = round_frac(uu * u);
        w1 = 3 * round_frac(uu * t);
        w2 = 3 * round_frac(tt * u);
        w3 = round_frac(tt * t);
      end else begin
        w0 = uu;
        w1 = 2 * round_frac(u * t);
        w2 = 0;
        w3 = tt;
      end
      return clip(round_frac(w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3));
    endfunction

    // Advances the motion by one accepted item and queues the sample it yields.
    function void note_input(logic [CMD_W-1:0] cmd, logic [DT_W-1:0] dt);
      longint        p, ax, ay;
      bit            run;
      curve_sample_t s;
      run = 1'b0;
      if (order != ORDER_CUBIC) quad_items++;
      if (cmd == CMD_RESTART) begin
        restarts++;
        t_acc = 0;
        done = 1'b0;
        run = 1'b1;
      end else begin
        ticks++;
        if (!done) begin
          p = t_acc + longint'(speed) * longint'(dt);
          if (p < 0) begin
            p = 0;
            zero_clamps++;
          end
          if (p > UNIT_T) begin
            p = UNIT_T;
            done = 1'b1;
            finishes++;
          end else if (p == UNIT_T) begin
            landings++;
          end
          t_acc = p;
          run = 1'b1;
        end
      end
      if (run) begin
        ax = curve_axis(t_acc, 1'b0);
        ay = curve_axis(t_acc, 1'b1);
        held_x = ax[COORD_BITS_DEF-1:0];
        held_y = ay[COORD_BITS_DEF-1:0];
      end
      s.x = held_x;
      s.y = held_y;
      s.position = t_acc[FRAC_BITS_DEF:0];
      s.finished = done;
      pending_samples.push_back(s);
    endfunction

    function void check_result(logic signed [COORD_BITS_DEF-1:0] x,
                               logic signed [COORD_BITS_DEF-1:0] y,
                               logic [FRAC_BITS_DEF:0] pos, logic fin);
      curve_sample_t want;
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("Result x=%0d y=%0d pos=%0d fin=%0b arrived with none due.",
                               x, y, pos, fin));
        return;
      end
      want = pending_samples.pop_front();
      checked++;
      if (x !== want.x || y !== want.y || pos !== want.position || fin !== want.finished)
        note_failure($sformatf(
          "Result %0d differs: expected x=%0d y=%0d pos=%0d fin=%0b, got x=%0d y=%0d pos=%0d fin=%0b.",
          checked, want.x, want.y, want.position, want.finished, x, y, pos, fin));
    endfunction

    function void close_out();
      if (pending_samples.size() != 0)
        note_failure($sformatf("%0d results never arrived.", pending_samples.size()));
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the Bezier path motion evaluator. Directed items cover the
// reset state, exact landing on the end, running past the end, clamping at
// zero, extreme speeds and coordinates in both curve orders. Random phases
// then program fresh curves and run restart and tick sequences under three
// idling mixes, one of them with a long receiver hold-off.
module tb_top;
  import bpme_pkg::*;
  import bpme_tb_pkg::*;

  // A cubic tick takes 15 multiplies; this margin covers them plus the
  // output register after the last item.
  localparam int RESULT_DRAIN_CYCLES = 600;
  localparam int LONG_HOLD_CYCLES    = 3000;
  localparam int ITEMS_PER_PHASE     = 150;
  localparam int RANDOM_PHASES       = 6;

  // Register indexes past the last register; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [CMD_W-1:0]     CMD_TICK     = 1'b0;

  logic clk;
  logic rst_n;
  logic hold_rx = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;

  motion_scoreboard sb;

  bpme_in_if  in_ch ();
  bpme_out_if out_ch ();
  bpme_cfg_if cfg_ch ();

  bezier_path_motion_evaluator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The slowest correct run is well under 4 ms (about 925 items of up to 15
  // multiplies each, plus the hold-off); allow several times that.
  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver. It drops ready at random, and keeps it low all through a long
  // hold-off, so that the output register stays full and the block backs
  // up into its input channel.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n || hold_rx) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  // Every handshake is observed here, with the values that stood before the
  // edge, so the prediction follows the order in which the block took items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.cmd, in_ch.time_delay);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.point_x, out_ch.point_y, out_ch.position, out_ch.finished);
    end
  end

  // Offers one item after a random gap and returns at the edge that took it.
  // Valid is left high so that a following item goes out without a bubble.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DT_W-1:0] dt);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.time_delay <= dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Writes one register; valid stays high for back-to-back writes and the
  // caller lowers it after the last one.
  task automatic write_cfg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Stops offering items and waits until every owed result has been taken.
  // The first edge lets the last accepted item reach the scoreboard. Since
  // each item yields exactly one result, the block is idle afterwards.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_samples.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PT_W-1:0] pick_coord(bit extreme);
    logic [PT_W-1:0] c;
    c = PT_W'($urandom);
    if (extreme || $urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: c = 16'h8000;
        1: c = 16'h7FFF;
        2: c = 16'h0000;
        default: c = 16'hFFFF;
      endcase
    end
    return c;
  endfunction

  // Most speeds are small enough that a motion takes a handful of ticks;
  // some are full range, and the bits above the speed field are random junk.
  function automatic logic [CFG_DATA_W-1:0] pick_speed();
    logic [CFG_DATA_W-1:0] raw;
    logic [SPEED_W-1:0]    mag;
    raw = $urandom;
    if ($urandom_range(7) == 0) return raw;
    mag = raw[SPEED_W-1:0] & ((24'd1 << $urandom_range(8, 21)) - 24'd1);
    if ($urandom_range(6) == 0) mag = -mag;
    return {raw[CFG_DATA_W-1:SPEED_W], mag};
  endfunction

  task automatic program_curve(input bit extreme);
    write_cfg(REG_START_POINT, {pick_coord(extreme), pick_coord(extreme)});
    write_cfg(REG_CONTROL_A, {pick_coord(extreme), pick_coord(extreme)});
    write_cfg(REG_CONTROL_B, {pick_coord(extreme), pick_coord(extreme)});
    write_cfg(REG_END_POINT, {pick_coord(extreme), pick_coord(extreme)});
    write_cfg(REG_SPEED, pick_speed());
    write_cfg(REG_CURVE_ORDER, $urandom);
    if ($urandom_range(1) == 0) write_cfg(IDX_SPARE_HI, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // Restart followed by ticks, with an occasional restart in mid-motion.
  // Elapsed times are mostly short so the motion crosses the curve in steps.
  task automatic run_random_phase(input int n);
    logic [CMD_W-1:0] cmd;
    logic [DT_W-1:0]  dt;
    for (int i = 0; i < n; i++) begin
      cmd = (i == 0 || $urandom_range(9) == 0) ? CMD_RESTART : CMD_TICK;
      dt = ($urandom_range(3) == 0) ? DT_W'($urandom) : DT_W'($urandom_range(64));
      send_item(cmd, dt);
    end
  endtask

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.time_delay <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_START_POINT;
    cfg_ch.data      <= '0;
    send_idle_pct = 12;
    recv_idle_pct = 66;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks straight after reset: the motion counts as finished, so the
    // held origin comes back with the finished flag set.
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'hFFFF);
    settle();

    // Coordinate extremes, a speed that lands exactly on 1.0 after sixteen
    // units, and writes to the two unused indexes.
    write_cfg(REG_START_POINT, 32'h8000_7FFF);
    write_cfg(REG_CONTROL_A, 32'h7FFF_8000);
    write_cfg(REG_CONTROL_B, 32'h8000_8000);
    write_cfg(REG_END_POINT, 32'h7FFF_7FFF);
    write_cfg(REG_SPEED, 32'h0010_0000);
    write_cfg(REG_CURVE_ORDER, {31'd0, ORDER_CUBIC});
    write_cfg(IDX_SPARE_LO, $urandom);
    write_cfg(IDX_SPARE_HI, $urandom);
    cfg_ch.valid <= 1'b0;
    send_item(CMD_RESTART, 16'h0000);
    send_item(CMD_TICK, 16'h0000);
    send_item(CMD_TICK, 16'h0001);
    // Lands exactly on the end point; the motion must still be running.
    send_item(CMD_TICK, 16'h000F);
    // Goes past the end and finishes.
    send_item(CMD_TICK, 16'h0001);
    // Tick while finished leaves everything as it was.
    send_item(CMD_TICK, 16'hFFFF);
    // The elapsed time of a restart is ignored.
    send_item(CMD_RESTART, 16'hFFFF);
    settle();

    // Most negative speed: the sum drops below zero and is held at zero.
    write_cfg(REG_SPEED, 32'h0080_0000);
    cfg_ch.valid <= 1'b0;
    send_item(CMD_TICK, 16'hFFFF);
    send_item(CMD_TICK, 16'h0001);
    settle();

    // Quadratic curve at the largest positive speed; junk in the upper bits.
    write_cfg(REG_SPEED, 32'hFF7F_FFFF);
    write_cfg(REG_CURVE_ORDER, 32'hFFFF_FFFE);
    cfg_ch.valid <= 1'b0;
    send_item(CMD_RESTART, 16'h1234);
    send_item(CMD_TICK, 16'h0001);
    send_item(CMD_TICK, 16'hFFFF);
    settle();

    // A slow quadratic motion over the early part of the curve.
    write_cfg(REG_SPEED, 32'hAB00_0123);
    cfg_ch.valid <= 1'b0;
    send_item(CMD_RESTART, 16'h0000);
    send_item(CMD_TICK, 16'h1000);
    send_item(CMD_TICK, 16'h1000);
    send_item(CMD_TICK, 16'h1000);
    settle();

    // All points at the same corner, so rounding can push the sum past the
    // coordinate range and saturation shows on both signs.
    write_cfg(REG_START_POINT, 32'h8000_7FFF);
    write_cfg(REG_CONTROL_A, 32'h8000_7FFF);
    write_cfg(REG_CONTROL_B, 32'h8000_7FFF);
    write_cfg(REG_END_POINT, 32'h8000_7FFF);
    write_cfg(REG_SPEED, 32'h0001_2345);
    write_cfg(REG_CURVE_ORDER, {31'd0, ORDER_CUBIC});
    cfg_ch.valid <= 1'b0;
    send_item(CMD_RESTART, 16'h0000);
    send_item(CMD_TICK, 16'd100);
    send_item(CMD_TICK, 16'd333);
    send_item(CMD_TICK, 16'd1000);
    settle();

    // Random phases: two with a slow receiver, two with a slow sender, two
    // with neither idling. The first of the last pair opens with a long
    // hold-off on the receiver while items keep coming.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 66;
        recv_idle_pct = 12;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_curve(ph == 0 || ph == 3);
      if (ph == 4) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      run_random_phase(ITEMS_PER_PHASE);
      settle();
    end

    repeat (RESULT_DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    $display("Covered %0d items: %0d restarts, %0d ticks, %0d in quadratic mode; %0d results checked.",
             sb.restarts + sb.ticks, sb.restarts, sb.ticks, sb.quad_items, sb.checked);
    $display("Motion ran past the end %0d times, landed on 1.0 %0d times, was held at 0 %0d times.",
             sb.finishes, sb.landings, sb.zero_clamps);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures in total.", sb.failures);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
